>>> rtl/core/lph_pkg.sv
// shared widths, register map and control types for the hash table unit
`timescale 1ns / 1ps

package lph_pkg;

  localparam int REG_W  = 11;
  localparam int KEY_W  = 31;
  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int DIV_CW = $clog2(KEY_W);

  localparam logic [REG_W-1:0] HASH_MODULUS_RST = 11'd1024;
  localparam logic [REG_W-1:0] TABLE_SLOTS_RST  = 11'd1024;

  localparam logic REG_HASH_MODULUS = 1'b0;
  localparam logic REG_TABLE_SLOTS  = 1'b1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_step;
    logic reload;
    logic set_ptr;
    logic probe;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic need_reduce;
    logic hit_empty;
    logic probe_last;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/core/lph_chan_if.sv
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface lph_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [lph_pkg::KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface lph_out_if;
  logic                       valid;
  logic                       ready;
  logic [lph_pkg::SLOT_W-1:0] slot;
  logic [lph_pkg::CNT_W-1:0]  probe_count;
  logic                       table_full;

  modport source (output valid, output slot, output probe_count, output table_full,
                  input ready);
  modport sink (input valid, input slot, input probe_count, input table_full,
                output ready);
endinterface

>>> rtl/core/lph_cfg.sv
// configuration registers with apb access and effective value clamping
`timescale 1ns / 1ps

module lph_cfg #(
  parameter int TABLE_DEPTH = 1024,
  localparam int DW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lph_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [lph_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [lph_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic [DW-1:0]              eff_mod,
  output logic [DW-1:0]              eff_slots
);

  localparam int EW = (DW > lph_pkg::REG_W) ? DW : lph_pkg::REG_W;

  logic [lph_pkg::REG_W-1:0] hash_modulus_r, hash_modulus_nxt;
  logic [lph_pkg::REG_W-1:0] table_slots_r, table_slots_nxt;
  logic                      wr_en;
  logic [EW-1:0]             mod_ext, slots_ext;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    hash_modulus_nxt = hash_modulus_r;
    table_slots_nxt  = table_slots_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        lph_pkg::REG_HASH_MODULUS: hash_modulus_nxt = cfg_pwdata[lph_pkg::REG_W-1:0];
        lph_pkg::REG_TABLE_SLOTS:  table_slots_nxt  = cfg_pwdata[lph_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_modulus_r <= lph_pkg::HASH_MODULUS_RST;
      table_slots_r  <= lph_pkg::TABLE_SLOTS_RST;
    end else begin
      hash_modulus_r <= hash_modulus_nxt;
      table_slots_r  <= table_slots_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      lph_pkg::REG_HASH_MODULUS:
        cfg_prdata = lph_pkg::APB_DW'(hash_modulus_r);
      lph_pkg::REG_TABLE_SLOTS:
        cfg_prdata = lph_pkg::APB_DW'(table_slots_r);
      default: cfg_prdata = '0;
    endcase
  end

  // zero reads as one, anything above the depth as the depth
  always_comb begin
    mod_ext   = EW'(hash_modulus_r);
    slots_ext = EW'(table_slots_r);
    if (mod_ext == '0) begin
      eff_mod = DW'(1);
    end else if (mod_ext > EW'(TABLE_DEPTH)) begin
      eff_mod = DW'(TABLE_DEPTH);
    end else begin
      eff_mod = mod_ext[DW-1:0];
    end
    if (slots_ext == '0) begin
      eff_slots = DW'(1);
    end else if (slots_ext > EW'(TABLE_DEPTH)) begin
      eff_slots = DW'(TABLE_DEPTH);
    end else begin
      eff_slots = slots_ext[DW-1:0];
    end
  end

endmodule

>>> rtl/core/lph_datapath.sv
// remainder unit, probe pointer, slot valid memory and result register
`timescale 1ns / 1ps

module lph_datapath #(
  parameter int TABLE_DEPTH = 1024,
  localparam int DW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lph_pkg::cmd_t              cmd,
  output lph_pkg::sts_t              sts,
  input  logic                       in_mode,
  input  logic [lph_pkg::KEY_W-1:0]  in_key,
  input  logic [DW-1:0]              eff_mod,
  input  logic [DW-1:0]              eff_slots,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lph_pkg::SLOT_W-1:0] out_slot,
  output logic [lph_pkg::CNT_W-1:0]  out_probe_count,
  output logic                       out_table_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 2);

  logic                        mode_r;
  logic [lph_pkg::KEY_W-1:0]   dvd_r;
  logic [DW-1:0]               dvs_r;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [lph_pkg::DIV_CW-1:0]  div_cnt_r;
  logic [DW:0]                 trial;
  logic [AW-1:0]               p_r, p_wrap;
  logic [DW-1:0]               p_ext;
  logic [CW-1:0]               cnt_r, cnt_inc;
  logic [AW-1:0]               clr_addr_r;
  logic [AW-1:0]               res_slot_r;
  logic                        res_full_r;
  logic                        vmem_r [TABLE_DEPTH];
  logic                        rd_r;
  logic                        mem_we, mem_wd;
  logic [AW-1:0]               mem_addr;
  logic                        out_valid_r;
  logic [lph_pkg::SLOT_W-1:0]  out_slot_r;
  logic [lph_pkg::CNT_W-1:0]   out_cnt_r;
  logic                        out_full_r;

  // restoring remainder, one quotient bit a cycle
  always_comb begin
    trial = {rem_r, dvd_r[lph_pkg::KEY_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      dvd_r     <= in_key;
      dvs_r     <= (in_mode == lph_pkg::MODE_QUERY) ? eff_slots : eff_mod;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.reload) begin
      dvd_r     <= lph_pkg::KEY_W'(rem_r);
      dvs_r     <= eff_slots;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= {dvd_r[lph_pkg::KEY_W-2:0], 1'b0};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  assign p_ext   = DW'(p_r) + DW'(1);
  assign p_wrap  = (p_ext == eff_slots) ? '0 : p_ext[AW-1:0];
  assign cnt_inc = cnt_r + 1'b1;

  assign sts.div_last    = (div_cnt_r == lph_pkg::DIV_CW'(lph_pkg::KEY_W - 1));
  assign sts.need_reduce = (mode_r == lph_pkg::MODE_INSERT) && (rem_r >= eff_slots);
  assign sts.hit_empty   = !rd_r;
  assign sts.probe_last  = (mode_r == lph_pkg::MODE_QUERY) ?
                           (cnt_inc == CW'(eff_slots) + CW'(1)) :
                           (cnt_inc == CW'(eff_slots));
  assign sts.clear_last  = (clr_addr_r == AW'(TABLE_DEPTH - 1));
  assign sts.out_busy    = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.set_ptr) begin
      p_r   <= rem_r[AW-1:0];
      cnt_r <= '0;
    end else if (cmd.probe) begin
      cnt_r <= cnt_inc;
      if (!sts.hit_empty && !sts.probe_last) begin
        p_r <= p_wrap;
      end
      res_slot_r <= sts.hit_empty ? p_r : '0;
      res_full_r <= !sts.hit_empty && (mode_r == lph_pkg::MODE_INSERT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear && !sts.clear_last) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign mem_we   = cmd.clear ||
                    (cmd.probe && sts.hit_empty && (mode_r == lph_pkg::MODE_INSERT));
  assign mem_wd   = !cmd.clear;
  assign mem_addr = cmd.clear ? clr_addr_r : p_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem_r[mem_addr] <= mem_wd;
    end
    rd_r <= vmem_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot_r <= lph_pkg::SLOT_W'(res_slot_r);
      out_cnt_r  <= lph_pkg::CNT_W'(cnt_r);
      out_full_r <= res_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_probe_count = out_cnt_r;
  assign out_table_full  = out_full_r;

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result not presented after emit");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (cnt_inc <= CW'(eff_slots) + CW'(1)))
    else $error("probe count beyond slots plus one");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && res_full_r |-> (mode_r == lph_pkg::MODE_INSERT))
    else $error("full flag on a query");

endmodule

>>> rtl/core/lph_ctrl.sv
// sequencing state machine for clear, remainder, probe and result transfer
`timescale 1ns / 1ps

module lph_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lph_pkg::sts_t sts,
  output lph_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_HOME  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_HOME;
      end
      S_HOME: begin
        if (sts.need_reduce) begin
          cmd.reload = 1'b1;
          state_nxt  = S_DIV;
        end else begin
          cmd.set_ptr = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.probe = 1'b1;
        state_nxt = (sts.hit_empty || sts.probe_last) ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result overwrites a pending transfer");

  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !cmd.load && !cmd.probe)
    else $error("item work during clearing pass");

  a_probe_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> $past(state_r) == S_READ)
    else $error("probe without memory read");

endmodule

>>> rtl/core/linear_probe_hash_table_unit.sv
// top level of the linear probing hash table unit
// an item runs through the remainder steps, the home check, a memory read and a check per probe
//   and the result load; the remainder steps run once more when the home slot is reduced again
// a new item is taken only once the last one's result is loaded, later while an earlier result waits
// for transfer; the bit-serial remainder unit and the single-port slot memory set this pace
// after reset a clearing pass over every slot empties the slot memory; no item is
//   taken meanwhile, configuration writes are taken as ever
`timescale 1ns / 1ps

module linear_probe_hash_table_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lph_in_if.sink                     in_chan,
  lph_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lph_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [lph_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [lph_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int DW = $clog2(TABLE_DEPTH + 1);

  lph_pkg::cmd_t cmd;
  lph_pkg::sts_t sts;
  logic [DW-1:0] eff_mod, eff_slots;

  lph_cfg #(.TABLE_DEPTH(TABLE_DEPTH)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .eff_mod     (eff_mod),
    .eff_slots   (eff_slots)
  );

  lph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lph_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_chan.mode),
    .in_key          (in_chan.key),
    .eff_mod         (eff_mod),
    .eff_slots       (eff_slots),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_slot        (out_chan.slot),
    .out_probe_count (out_chan.probe_count),
    .out_table_full  (out_chan.table_full)
  );

endmodule

>>> dv/lph_table_checker.sv
// checker for the hash table unit: tracks slot occupancy and compares every result transfer
`timescale 1ns / 1ps

module lph_table_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lph_in_if                          in_mon,
  lph_out_if                         out_mon,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [lph_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [lph_pkg::APB_DW-1:0] cfg_pwdata,
  output int                         fail_count,
  output int                         pending,
  output int                         full_count
);
  import lph_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  probe_count;
    logic              table_full;
  } outcome_t;

  logic             occupied [TABLE_DEPTH];
  logic [REG_W-1:0] modulus_reg;
  logic [REG_W-1:0] slots_reg;
  outcome_t         owed_outcomes [$];
  int               accepted;
  int               retired;

  initial begin
    fail_count = 0;
    full_count = 0;
    accepted   = 0;
    retired    = 0;
  end

  assign pending = accepted - retired;

  function automatic int unsigned clamp_reg(input logic [REG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(v);
  endfunction

  // walks the table the way the block does and returns what it should report
  function automatic outcome_t probe_table(input logic mode, input logic [KEY_W-1:0] key);
    int unsigned slots;
    int unsigned modulus;
    int unsigned pos;
    int unsigned tries;
    int unsigned limit;
    bit          found;
    outcome_t    r;
    slots   = clamp_reg(slots_reg);
    modulus = clamp_reg(modulus_reg);
    found   = 1'b0;
    tries   = 0;
    r       = '0;
    if (mode == MODE_INSERT) begin
      pos = {1'b0, key} % modulus;
      if (pos >= slots) pos = pos % slots;
      limit = slots;
    end else begin
      pos   = {1'b0, key} % slots;
      limit = slots + 1;
    end
    while (!found && tries < limit) begin
      tries++;
      if (!occupied[pos]) begin
        found  = 1'b1;
        r.slot = SLOT_W'(pos);
        if (mode == MODE_INSERT) occupied[pos] = 1'b1;
      end else begin
        pos = (pos + 1 == slots) ? 0 : pos + 1;
      end
    end
    r.probe_count = CNT_W'(tries);
    if (mode == MODE_INSERT && !found) r.table_full = 1'b1;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("checker: %s got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) occupied[i] = 1'b0;
      modulus_reg = HASH_MODULUS_RST;
      slots_reg   = TABLE_SLOTS_RST;
      owed_outcomes.delete();
      accepted = 0;
      retired  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == APB_AW'({REG_HASH_MODULUS, 2'b00}))
          modulus_reg = cfg_pwdata[REG_W-1:0];
        else if (cfg_paddr == APB_AW'({REG_TABLE_SLOTS, 2'b00}))
          slots_reg = cfg_pwdata[REG_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_outcomes.push_back(probe_table(in_mon.mode, in_mon.key));
        accepted++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_outcomes.size() == 0) begin
          flag_mismatch("result transfer with nothing outstanding, slot", out_mon.slot, -1);
        end else begin
          if (out_mon.slot !== owed_outcomes[0].slot)
            flag_mismatch("slot", out_mon.slot, owed_outcomes[0].slot);
          if (out_mon.probe_count !== owed_outcomes[0].probe_count)
            flag_mismatch("probe_count", out_mon.probe_count, owed_outcomes[0].probe_count);
          if (out_mon.table_full !== owed_outcomes[0].table_full)
            flag_mismatch("table_full", out_mon.table_full, owed_outcomes[0].table_full);
          if (owed_outcomes[0].table_full) full_count++;
          void'(owed_outcomes.pop_front());
          retired++;
        end
      end
    end
  end

endmodule

>>> dv/linear_probe_hash_table_unit_tb.sv
// testbench top for the hash table unit: stimulus, register settings and verdict
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;
  import lph_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int ITEM_TARGET  = 1850;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 2200;
  localparam int CYCLE_LIMIT  = 12_500_000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int full_count;
  int items_sent   = 0;
  int inserts_sent = 0;
  int settings     = 0;
  int cycles       = 0;
  int stall_left   = 0;
  bit no_gaps      = 1'b0;
  bit phase_calm   = 1'b0;

  lph_in_if  in_ch ();
  lph_out_if out_ch ();

  linear_probe_hash_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_ch),
    .out_chan   (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  lph_table_checker #(
    .TABLE_DEPTH(DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_pready (cfg_pready),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .full_count (full_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("linear_probe_hash_table_unit: mismatch");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (!no_gaps && !phase_calm && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(0, 15);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_item(input logic mode, input logic [KEY_W-1:0] key);
    int gap;
    if (!no_gaps && !phase_calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.mode  = mode;
    in_ch.key   = key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (mode == MODE_INSERT) inserts_sent++;
    if (items_sent >= ITEM_TARGET - CALM_TAIL) no_gaps = 1'b1;
  endtask

  // hold off until every owed result has been transferred
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
    logic [APB_DW-1:0] noise;
    noise = $urandom();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = APB_AW'({idx, 2'b00});
    cfg_pwdata  = {noise[APB_DW-1:REG_W], value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic configure(input logic [REG_W-1:0] modulus, input logic [REG_W-1:0] slots);
    settle();
    write_reg(REG_HASH_MODULUS, modulus);
    write_reg(REG_TABLE_SLOTS, slots);
    settings++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {KEY_W{1'b1}};
    if (r <= 4) return KEY_W'($urandom_range(0, 4095));
    return KEY_W'($urandom());
  endfunction

  initial begin
    logic [REG_W-1:0] slots;
    logic [REG_W-1:0] modulus;
    int               r;
    int               len;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_INSERT;
    in_ch.key      = '0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: duplicates, wrap past the last slot, queries into a cluster
    send_item(MODE_INSERT, '0);
    send_item(MODE_INSERT, '0);
    send_item(MODE_INSERT, {KEY_W{1'b1}});
    send_item(MODE_INSERT, KEY_W'(1023));
    send_item(MODE_INSERT, KEY_W'(1024));
    send_item(MODE_QUERY, KEY_W'(1023));
    send_item(MODE_QUERY, KEY_W'(32'h4000_0000));
    send_item(MODE_QUERY, KEY_W'(500));
    send_item(MODE_QUERY, {KEY_W{1'b1}});

    // zero registers act as one: full insert and a query with no empty slot
    configure('0, '0);
    send_item(MODE_INSERT, KEY_W'(5));
    send_item(MODE_QUERY, KEY_W'(7));

    // oversized registers are clipped to the table depth
    configure({REG_W{1'b1}}, 11'd2000);
    send_item(MODE_INSERT, KEY_W'(2047));
    send_item(MODE_QUERY, KEY_W'(1023));

    // home slot beyond the slots in use is reduced again
    configure(11'd1000, 11'd6);
    send_item(MODE_INSERT, KEY_W'(1999));
    send_item(MODE_INSERT, KEY_W'(3));
    send_item(MODE_QUERY, KEY_W'(11));

    configure(11'd1, 11'd1024);
    send_item(MODE_INSERT, KEY_W'(32'h1234_5678));
    send_item(MODE_QUERY, '0);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r == 0) slots = REG_W'($urandom_range(0, 1));
      else if (r == 1) slots = REG_W'($urandom_range(1024, 2047));
      else if (r <= 5) slots = REG_W'($urandom_range(2, 64));
      else if (r <= 8) slots = REG_W'($urandom_range(65, 256));
      else slots = REG_W'($urandom_range(257, 1023));
      r = $urandom_range(0, 9);
      if (r == 0) modulus = '0;
      else if (r == 1) modulus = REG_W'($urandom_range(1025, 2047));
      else if (r <= 4) modulus = REG_W'($urandom_range(1, 64));
      else modulus = REG_W'($urandom_range(1, 1024));
      len = (slots > 256) ? $urandom_range(10, 30) : $urandom_range(20, 80);
      configure(modulus, slots);
      phase_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len && items_sent < ITEM_TARGET; n++) begin
        send_item(($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_QUERY, pick_key());
        if (n == len / 2 && $urandom_range(0, 7) == 0) settle();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d inserts, %0d probe-count queries, %0d full-table inserts",
             items_sent, inserts_sent, items_sent - inserts_sent, full_count);
    $display("register settings applied: %0d, clock cycles: %0d", settings, cycles);
    if (fail_count == 0) begin
      $display("linear_probe_hash_table_unit: match");
    end else begin
      $display("linear_probe_hash_table_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lph_pkg.sv
rtl/core/lph_chan_if.sv
rtl/core/lph_cfg.sv
rtl/core/lph_datapath.sv
rtl/core/lph_ctrl.sv
rtl/core/linear_probe_hash_table_unit.sv
dv/lph_table_checker.sv
dv/linear_probe_hash_table_unit_tb.sv
